@@ hdl/i2a_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types, codes and helpers for the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

	// operation codes
	localparam logic [2:0] OP_CHAR    = 3'd0;
	localparam logic [2:0] OP_SDEC    = 3'd1;
	localparam logic [2:0] OP_UDEC    = 3'd2;
	localparam logic [2:0] OP_HEXL    = 3'd3;
	localparam logic [2:0] OP_HEXU    = 3'd4;
	localparam logic [2:0] OP_PTR     = 3'd5;
	localparam logic [2:0] OP_PERCENT = 3'd6;

	// fixed characters
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_X       = 8'h78;
	localparam logic [7:0] CH_MINUS   = 8'h2d;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;

	// digit counts and conversion length
	localparam logic [4:0] DEC_DIGITS   = 5'd10;
	localparam logic [4:0] HEX32_DIGITS = 5'd8;
	localparam logic [4:0] HEX64_DIGITS = 5'd16;
	localparam logic [4:0] CONV_LAST    = 5'd31;

	typedef struct packed {
		logic [2:0]  op;
		logic [63:0] value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_SKIP,
		S_SIGN,
		S_PFX0,
		S_PFX1,
		S_DIGIT,
		S_SINGLE
	} state_t;

	typedef enum logic [2:0] {
		SEL_BYTE,
		SEL_PERCENT,
		SEL_MINUS,
		SEL_ZERO,
		SEL_X,
		SEL_DIGIT
	} char_sel_t;

	typedef struct packed {
		logic      load;
		logic      conv_step;
		logic      skip_shift;
		logic      emit;
		char_sel_t char_sel;
		logic      last;
	} ctl_cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       neg;
		logic       top_zero;
		logic       cnt_one;
		logic       conv_done;
		logic       slot_free;
	} dp_status_t;

	// one digit value to its ASCII character
	function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
		logic [7:0] base;
		base = upper ? CH_UPPER_A : CH_LOWER_A;
		if (nib < 4'd10)
			hex_char = CH_ZERO + {4'd0, nib};
		else
			hex_char = base + {4'd0, nib} - 8'd10;
	endfunction

endpackage
`default_nettype wire

@@ hdl/i2a_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_ctrl
// Sequencer: load, binary to BCD steps, leading zero strip, prefix and digit
// emission.
// ----------------------------------------------------------------------------
module i2a_ctrl
	import i2a_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [2:0] in_op,
	output logic            in_ready,
	input  dp_status_t      status,
	output ctl_cmd_t        cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (in_op)
						OP_CHAR, OP_PERCENT:      state_d = S_SINGLE;
						OP_SDEC, OP_UDEC:         state_d = S_CONV;
						OP_HEXL, OP_HEXU, OP_PTR: state_d = S_SKIP;
						default:                  state_d = S_IDLE;
					endcase
				end
			end
			S_CONV: begin
				if (status.conv_done)
					state_d = S_SKIP;
			end
			S_SKIP: begin
				if (!(status.top_zero && !status.cnt_one)) begin
					if (status.neg)
						state_d = S_SIGN;
					else if (status.op == OP_PTR)
						state_d = S_PFX0;
					else
						state_d = S_DIGIT;
				end
			end
			S_SIGN: begin
				if (status.slot_free)
					state_d = S_DIGIT;
			end
			S_PFX0: begin
				if (status.slot_free)
					state_d = S_PFX1;
			end
			S_PFX1: begin
				if (status.slot_free)
					state_d = S_DIGIT;
			end
			S_DIGIT: begin
				if (status.slot_free && status.cnt_one)
					state_d = S_IDLE;
			end
			S_SINGLE: begin
				if (status.slot_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd      = '0;
		cmd.char_sel = SEL_DIGIT;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_CONV: cmd.conv_step = 1'b1;
			S_SKIP: cmd.skip_shift = status.top_zero && !status.cnt_one;
			S_SIGN: begin
				cmd.emit     = status.slot_free;
				cmd.char_sel = SEL_MINUS;
			end
			S_PFX0: begin
				cmd.emit     = status.slot_free;
				cmd.char_sel = SEL_ZERO;
			end
			S_PFX1: begin
				cmd.emit     = status.slot_free;
				cmd.char_sel = SEL_X;
			end
			S_DIGIT: begin
				cmd.emit     = status.slot_free;
				cmd.char_sel = SEL_DIGIT;
				cmd.last     = status.cnt_one;
			end
			S_SINGLE: begin
				cmd.emit     = status.slot_free;
				cmd.char_sel = (status.op == OP_PERCENT) ? SEL_PERCENT : SEL_BYTE;
				cmd.last     = 1'b1;
			end
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

@@ hdl/i2a_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_dpath
// Argument registers, shift-add-3 BCD converter, digit shifter and the
// output beat register.
// ----------------------------------------------------------------------------
module i2a_dpath
	import i2a_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  in_item_t   in_data,
	input  ctl_cmd_t   cmd,
	output dp_status_t status,
	output logic       out_valid,
	input  wire logic  out_ready,
	output out_item_t  out_data
);

	logic [2:0]  op_q;
	logic        neg_q;
	logic [31:0] bin_q;
	logic [63:0] digits_q;
	logic [4:0]  cnt_q;
	logic [4:0]  iter_q;
	logic        out_valid_q;
	out_item_t   out_data_q;

	logic [31:0] low32;
	logic        neg_in;
	logic [31:0] mag;
	logic [39:0] bcd_adj;
	logic [7:0]  next_char;

	assign low32  = in_data.value[31:0];
	assign neg_in = (in_data.op == OP_SDEC) && low32[31];
	assign mag    = neg_in ? (32'd0 - low32) : low32;

	// add 3 to every BCD digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < 10; i++) begin
			if (digits_q[24 + 4*i +: 4] >= 4'd5)
				bcd_adj[4*i +: 4] = digits_q[24 + 4*i +: 4] + 4'd3;
			else
				bcd_adj[4*i +: 4] = digits_q[24 + 4*i +: 4];
		end
	end

	// argument, digit and count registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= in_data.op;
			neg_q  <= neg_in;
			bin_q  <= mag;
			iter_q <= '0;
			case (in_data.op)
				OP_SDEC, OP_UDEC: begin
					digits_q <= '0;
					cnt_q    <= DEC_DIGITS;
				end
				OP_HEXL, OP_HEXU: begin
					digits_q <= {low32, 32'd0};
					cnt_q    <= HEX32_DIGITS;
				end
				OP_PTR: begin
					digits_q <= in_data.value;
					cnt_q    <= HEX64_DIGITS;
				end
				default: begin
					digits_q <= '0;
					cnt_q    <= 5'd1;
				end
			endcase
		end else if (cmd.conv_step) begin
			digits_q[63:24] <= {bcd_adj[38:0], bin_q[31]};
			bin_q           <= {bin_q[30:0], 1'b0};
			iter_q          <= iter_q + 5'd1;
		end else if (cmd.skip_shift || (cmd.emit && cmd.char_sel == SEL_DIGIT)) begin
			digits_q <= {digits_q[59:0], 4'd0};
			cnt_q    <= cnt_q - 5'd1;
		end
	end

	// character for the current beat
	always_comb begin
		case (cmd.char_sel)
			SEL_BYTE:    next_char = bin_q[7:0];
			SEL_PERCENT: next_char = CH_PERCENT;
			SEL_MINUS:   next_char = CH_MINUS;
			SEL_ZERO:    next_char = CH_ZERO;
			SEL_X:       next_char = CH_X;
			default:     next_char = hex_char(digits_q[63:60], op_q == OP_HEXU);
		endcase
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q.char_code <= next_char;
			out_data_q.last      <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign status.op        = op_q;
	assign status.neg       = neg_q;
	assign status.top_zero  = (digits_q[63:60] == 4'd0);
	assign status.cnt_one   = (cnt_q == 5'd1);
	assign status.conv_done = (iter_q == CONV_LAST);
	assign status.slot_free = !out_valid_q || out_ready;

endmodule
`default_nettype wire

@@ hdl/integer_to_ascii_formatter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Turns one conversion request into its ASCII characters, one per beat.
// ----------------------------------------------------------------------------
// One request is handled at a time; in_ready is high only between requests.
// A char or percent request is a load and then its single beat. Hex requests
// load, strip leading zero digits one at a time, leave the strip and then
// emit each character; a pointer adds its 0x prefix first. Decimal requests
// first run shift-add-3 binary to BCD conversion over all 32 argument bits,
// one bit per cycle, and a negative signed value adds a minus sign before the
// digits. A beat waits while the output register still holds an unaccepted
// one, so out_ready stalls hold the sequence back.
// Characters leave through an output register at one per cycle while
// out_ready stays high; the last character of a request carries last = 1.
// Op code 7 is accepted and produces nothing.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter
	import i2a_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_item_t out_data
);

	ctl_cmd_t   cmd;
	dp_status_t status;

	// sequencer
	i2a_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (in_data.op),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath
	i2a_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// a new beat never overwrites one still waiting
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.slot_free)
		else $error("beat emitted over a pending beat");

	// conversion stops after its final step
	a_conv_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.conv_step && status.conv_done) |=> !cmd.conv_step)
		else $error("BCD conversion ran past 32 steps");

	// the final digit returns the block to taking requests
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |=> in_ready)
		else $error("not ready after last beat");

	// zero stripping always leaves one digit
	a_keep_digit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.skip_shift |-> !status.cnt_one)
		else $error("stripped the final digit");

endmodule
`default_nettype wire

@@ bench/integer_to_ascii_formatter_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_checker
// Watches both channels of the formatter and checks every character beat.
// Each accepted request is expanded into the characters it must produce,
// and each output beat is compared field by field with the oldest of them.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_checker
	import i2a_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_ready,
	input  in_item_t  in_data,
	input  wire logic out_valid,
	input  wire logic out_ready,
	input  out_item_t out_data,
	output int        fail_count,
	output int        pending_chars
);

	localparam int MAX_REPORTS = 10;

	string lower_digits = "0123456789abcdef";
	string upper_digits = "0123456789ABCDEF";

	out_item_t expected_chars[$];
	int        mismatches = 0;

	// expand one request into its characters, most significant digit first
	function automatic void expand_request(input in_item_t req);
		logic [7:0]  text [0:19];
		logic [7:0]  rev [0:19];
		int          text_len;
		int          rev_len;
		logic [31:0] low_word;
		logic [63:0] magnitude;
		logic [63:0] radix;
		logic [63:0] digit;
		logic        numeric;
		logic        upper;
		out_item_t   beat;
		text_len  = 0;
		rev_len   = 0;
		low_word  = req.value[31:0];
		magnitude = '0;
		radix     = 64'd10;
		numeric   = 1'b0;
		upper     = 1'b0;
		case (req.op)
			OP_CHAR: begin
				text[text_len] = req.value[7:0];
				text_len++;
			end
			OP_SDEC: begin
				numeric = 1'b1;
				if (low_word[31]) begin
					text[text_len] = CH_MINUS;
					text_len++;
					magnitude = {32'd0, 32'd0 - low_word};
				end else begin
					magnitude = {32'd0, low_word};
				end
			end
			OP_UDEC: begin
				numeric   = 1'b1;
				magnitude = {32'd0, low_word};
			end
			OP_HEXL, OP_HEXU: begin
				numeric   = 1'b1;
				radix     = 64'd16;
				upper     = (req.op == OP_HEXU);
				magnitude = {32'd0, low_word};
			end
			OP_PTR: begin
				numeric   = 1'b1;
				radix     = 64'd16;
				magnitude = req.value;
				text[text_len] = CH_ZERO;
				text_len++;
				text[text_len] = CH_X;
				text_len++;
			end
			OP_PERCENT: begin
				text[text_len] = CH_PERCENT;
				text_len++;
			end
			default: begin
				// unused code: no characters at all
			end
		endcase
		if (numeric) begin
			if (magnitude == 64'd0) begin
				text[text_len] = CH_ZERO;
				text_len++;
			end else begin
				// digits come out least significant first
				while (magnitude != 64'd0) begin
					digit = magnitude % radix;
					rev[rev_len] = upper ? upper_digits[digit] : lower_digits[digit];
					rev_len++;
					magnitude = magnitude / radix;
				end
				while (rev_len > 0) begin
					rev_len--;
					text[text_len] = rev[rev_len];
					text_len++;
				end
			end
		end
		for (int i = 0; i < text_len; i++) begin
			beat.char_code = text[i];
			beat.last      = (i == text_len - 1);
			expected_chars.push_back(beat);
		end
	endfunction

	// request side first, so a beat at the same edge still pops the older one
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			expected_chars.delete();
		end else begin
			if (in_valid && in_ready)
				expand_request(in_data);
			if (out_valid && out_ready) begin
				if (expected_chars.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("%0t: unexpected beat char_code=%h last=%b",
							$time, out_data.char_code, out_data.last);
					mismatches++;
				end else begin
					want = expected_chars.pop_front();
					if (out_data.char_code !== want.char_code ||
						out_data.last !== want.last) begin
						if (mismatches < MAX_REPORTS)
							$display("%0t: mismatch char_code exp=%h got=%h last exp=%b got=%b",
								$time, want.char_code, out_data.char_code,
								want.last, out_data.last);
						mismatches++;
					end
				end
			end
		end
		fail_count    <= mismatches;
		pending_chars <= expected_chars.size();
	end

endmodule

@@ bench/integer_to_ascii_formatter_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_test
// Drives conversion requests into the formatter and gives the verdict.
// A directed set covers every operation and the edge values, then random
// requests follow with random idling on both sides, a long output stall
// and a pause until the output has drained. The checker does the compare.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_test;
	import i2a_pkg::*;

	localparam logic [2:0] OP_UNUSED      = 3'd7;
	localparam int         RANDOM_REQS    = 250;
	localparam int         CALM_REQS      = 40;
	localparam int         LONG_HOLD      = 300;
	localparam int         HOLD_AT        = 60;
	localparam int         DRAIN_AT       = 150;
	localparam int         DRAIN_CYCLES   = 100;
	localparam int         WATCHDOG_LIMIT = 2000;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	in_item_t  in_data   = '0;
	logic      out_ready = 1'b0;
	logic      in_ready;
	logic      out_valid;
	out_item_t out_data;

	int fail_count;
	int pending_chars;
	int stall_cycles  = 0;
	int hold_request  = 0;
	int burst_left    = 0;
	bit calm          = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	integer_to_ascii_formatter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	integer_to_ascii_formatter_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data),
		.fail_count    (fail_count),
		.pending_chars (pending_chars)
	);

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
				if (stall_cycles >= WATCHDOG_LIMIT) begin
					$display("integer_to_ascii_formatter verification failed");
					$finish;
				end
			end
		end
	end

	// output side: ready runs, idle bursts and the long hold-off
	initial begin : output_pacing
		int hold_served;
		hold_served = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request != hold_served) begin
				hold_served++;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (calm) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 60)) @(posedge clk);
			end
		end
	end

	// hold the request until the block takes it
	task automatic push_request(input in_item_t req);
		in_data  <= req;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// one request, then maybe an idle burst on the input side
	task automatic offer(input logic [2:0] op, input logic [63:0] value);
		in_item_t req;
		req.op    = op;
		req.value = value;
		push_request(req);
		if (burst_left > 0) begin
			burst_left--;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// argument bits shaped toward short numbers, limits and digit boundaries
	function automatic logic [63:0] pick_value();
		logic [63:0] v;
		logic [31:0] p;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: ;
			1: v[31:0] = $urandom_range(0, 20);
			2: v[31:0] = v[31:0] >> $urandom_range(0, 31);
			3: begin
				p = 32'd1;
				repeat ($urandom_range(0, 9)) p = p * 32'd10;
				v[31:0] = p + $urandom_range(0, 2) - 32'd1;
			end
			4: begin
				case ($urandom_range(0, 3))
					0: v[31:0] = 32'h8000_0000;
					1: v[31:0] = 32'h7fff_ffff;
					2: v[31:0] = 32'hffff_ffff;
					default: v[31:0] = 32'h0000_0000;
				endcase
			end
			default: v = v >> $urandom_range(0, 63);
		endcase
		return v;
	endfunction

	initial begin : stimulus
		int       done_reqs;
		logic [2:0] op;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every operation at its edges
		offer(OP_CHAR,    64'hffff_ffff_ffff_ff00);
		offer(OP_CHAR,    64'h0000_0000_0000_00ff);
		offer(OP_CHAR,    64'h1234_5678_9abc_de80);
		offer(OP_SDEC,    64'h0000_0000_0000_0000);
		offer(OP_SDEC,    64'hffff_ffff_ffff_ffff);
		offer(OP_SDEC,    64'h0000_0000_7fff_ffff);
		offer(OP_SDEC,    64'h0000_0000_8000_0000);
		offer(OP_SDEC,    64'hffff_ffff_8000_0000);
		offer(OP_UDEC,    64'hffff_ffff_0000_0000);
		offer(OP_UDEC,    64'h0000_0000_ffff_ffff);
		offer(OP_UDEC,    64'h0000_0000_3b9a_ca00);
		offer(OP_HEXL,    64'h0000_0000_0000_0000);
		offer(OP_HEXL,    64'hffff_ffff_dead_beef);
		offer(OP_HEXL,    64'h0000_0000_0000_0010);
		offer(OP_HEXU,    64'h0000_0000_abcd_ef01);
		offer(OP_HEXU,    64'h0000_0000_ffff_ffff);
		offer(OP_PTR,     64'h0000_0000_0000_0000);
		offer(OP_PTR,     64'hffff_ffff_ffff_ffff);
		offer(OP_PTR,     64'h8000_0000_0000_0000);
		offer(OP_PTR,     64'h0000_0000_0000_0001);
		offer(OP_PERCENT, 64'h0000_0000_0000_0000);
		offer(OP_PERCENT, 64'hffff_ffff_ffff_ffff);
		offer(OP_UNUSED,  64'h0000_0000_0000_0000);
		offer(OP_UNUSED,  64'hffff_ffff_ffff_ffff);

		// random requests; unused codes do not count
		done_reqs = 0;
		while (done_reqs < RANDOM_REQS) begin
			if (done_reqs == RANDOM_REQS - CALM_REQS)
				calm = 1'b1;
			if ($urandom_range(0, 99) < 4) begin
				op = OP_UNUSED;
			end else begin
				op = 3'($urandom_range(0, 6));
				done_reqs++;
			end
			offer(op, pick_value());
			if (done_reqs == HOLD_AT && op != OP_UNUSED) begin
				// stall the output and keep offering back to back
				hold_request++;
				burst_left = 8;
			end
			if (done_reqs == DRAIN_AT && op != OP_UNUSED) begin
				// pause until every character has gone out
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending_chars != 0) @(posedge clk);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_chars != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending_chars == 0)
			$display("integer_to_ascii_formatter verification clean");
		else
			$display("integer_to_ascii_formatter verification failed");
		$finish;
	end

endmodule

@@ integer_to_ascii_formatter.f @@
hdl/i2a_pkg.sv
hdl/i2a_ctrl.sv
hdl/i2a_dpath.sv
hdl/integer_to_ascii_formatter.sv
bench/integer_to_ascii_formatter_checker.sv
bench/integer_to_ascii_formatter_test.sv
